### rtl/smx_pkg.sv
// smx_pkg: shared constants, types and state codes of the sysex message extractor
// no dependencies; imported by smx_collect, smx_emit and the top module
`timescale 1ns / 1ps

package smx_pkg;

   // message store
   localparam int MSG_BYTES   = 64;
   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int LEN_W       = 7;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 12;

   // beat layouts
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   // midi codes
   localparam logic [BYTE_W-1:0] BYTE_START    = 8'hf0;
   localparam logic [BYTE_W-1:0] BYTE_END      = 8'hf7;
   localparam logic [BYTE_W-1:0] BYTE_REALTIME = 8'hf8;

   localparam logic [LEN_W-1:0] MSG_LIMIT = LEN_W'(MSG_BYTES);

   // hand-off from the collector to the emitter
   typedef struct packed {
      logic                valid;
      logic [LEN_W-1:0]    length;
      logic [OFFSET_W-1:0] offset;
   } smx_launch_type;

   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_LOAD,
      EMIT_SEND
   } smx_emit_state_type;

endpackage

### rtl/smx_ram.sv
// smx_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module smx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/smx_collect.sv
// smx_collect: input side; filters midi bytes, writes message bytes to the store,
// launches emission on a completed message when output_room is set. depends on smx_pkg
`timescale 1ns / 1ps

module smx_collect (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [smx_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                          emit_idle,
   output logic                          wr_en,
   output logic [smx_pkg::ADDR_W-1:0]    wr_addr,
   output logic [smx_pkg::BYTE_W-1:0]    wr_data,
   output smx_pkg::smx_launch_type       launch
);
   import smx_pkg::*;

   logic                in_message_ff, in_message_in;
   logic [LEN_W-1:0]    fill_ff, fill_in;
   smx_launch_type      launch_ff, launch_in;

   logic                accept;
   logic [BYTE_W-1:0]   midi_byte;
   logic [OFFSET_W-1:0] sample_offset;
   logic                output_room;
   logic                start;
   logic                active;
   logic [LEN_W-1:0]    fill_now;
   logic [LEN_W-1:0]    fill_next;

   assign midi_byte     = req_tdata[BYTE_W-1:0];
   assign sample_offset = req_tdata[BYTE_W+OFFSET_W-1:BYTE_W];
   assign output_room   = req_tdata[BYTE_W+OFFSET_W];

   // no new beat while a message is being handed out
   assign req_tready = emit_idle & ~launch_ff.valid;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      start     = (midi_byte == BYTE_START);
      active    = start | in_message_ff;
      fill_now  = start ? '0 : fill_ff;
      fill_next = fill_now + LEN_W'(1);

      in_message_in    = in_message_ff;
      fill_in          = fill_ff;
      launch_in        = launch_ff;
      launch_in.valid  = 1'b0;
      wr_en            = 1'b0;
      wr_addr          = fill_now[ADDR_W-1:0];
      wr_data          = midi_byte;

      if (accept && midi_byte < BYTE_REALTIME && active) begin
         if (fill_now >= MSG_LIMIT) begin
            // buffer full: abort, byte dropped
            in_message_in = 1'b0;
            fill_in       = '0;
         end else begin
            wr_en = 1'b1;
            if (midi_byte == BYTE_END) begin
               in_message_in    = 1'b0;
               fill_in          = '0;
               launch_in.valid  = output_room;
               launch_in.length = fill_next;
               launch_in.offset = sample_offset;
            end else begin
               in_message_in = 1'b1;
               fill_in       = fill_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_message_ff   <= 1'b0;
         fill_ff         <= '0;
         launch_ff.valid <= 1'b0;
      end else begin
         in_message_ff   <= in_message_in;
         fill_ff         <= fill_in;
         launch_ff.valid <= launch_in.valid;
      end
      launch_ff.length <= launch_in.length;
      launch_ff.offset <= launch_in.offset;
   end

   assign launch = launch_ff;

endmodule

### rtl/smx_emit.sv
// smx_emit: output side; walks the stored message through the ram read port
// and presents one beat per byte. depends on smx_pkg
`timescale 1ns / 1ps

module smx_emit (
   input  logic                           clock,
   input  logic                           reset,
   input  smx_pkg::smx_launch_type        launch,
   output logic                           emit_idle,
   output logic                           rd_en,
   output logic [smx_pkg::ADDR_W-1:0]     rd_addr,
   input  logic [smx_pkg::BYTE_W-1:0]     rd_data,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [smx_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);
   import smx_pkg::*;

   smx_emit_state_type  state_ff, state_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic                last_ff, last_in;

   logic                taken;

   assign taken = (state_ff == EMIT_SEND) & rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         EMIT_IDLE: begin
            if (launch.valid) state_in = EMIT_LOAD;
         end
         EMIT_LOAD: begin
            state_in = EMIT_SEND;
         end
         EMIT_SEND: begin
            if (rsp_tready) state_in = last_ff ? EMIT_IDLE : EMIT_LOAD;
         end
         default: state_in = EMIT_IDLE;
      endcase
   end

   // datapath and ram read control
   always_comb begin
      addr_in   = addr_ff;
      len_in    = len_ff;
      offset_in = offset_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      rd_en     = 1'b0;
      rd_addr   = addr_ff + ADDR_W'(1);
      unique case (state_ff)
         EMIT_IDLE: begin
            rd_addr = '0;
            if (launch.valid) begin
               rd_en     = 1'b1;
               addr_in   = '0;
               len_in    = launch.length;
               offset_in = launch.offset;
            end
         end
         EMIT_LOAD: begin
            // read data of addr_ff is on the ram output now
            byte_in = rd_data;
            last_in = ({1'b0, addr_ff} + LEN_W'(1)) == len_ff;
         end
         EMIT_SEND: begin
            if (taken && !last_ff) begin
               rd_en   = 1'b1;
               addr_in = addr_ff + ADDR_W'(1);
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EMIT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      addr_ff   <= addr_in;
      len_ff    <= len_in;
      offset_ff <= offset_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
   end

   assign emit_idle  = (state_ff == EMIT_IDLE);
   assign rsp_tvalid = (state_ff == EMIT_SEND);
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - BYTE_W - LEN_W - OFFSET_W)'(0),
                        offset_ff, len_ff, byte_ff};

endmodule

### rtl/sysex_message_extractor_top.sv
// sysex_message_extractor_top: midi sysex deframer, collector + message store + emitter
// depends on smx_pkg, smx_ram, smx_collect, smx_emit
//
//   group  dir  beat contents
//   req_   in   tdata: midi_byte[7:0], sample_offset[19:8], output_room[20], zero pad
//   rsp_   out  tdata: msg_byte[7:0], msg_length[14:8], msg_offset[26:15], zero pad;
//                tlast: last_byte
//
// one input beat per cycle while no message is being sent out.
// a completed message (f7 with room) holds req_tready low until the emitter is idle again,
// also while rsp_tready is low; each byte takes one ram read and one output beat.
// synchronous reset clears the control state; the store is not cleared, only bytes
// written for the current message are read back.
`timescale 1ns / 1ps

module sysex_message_extractor_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [smx_pkg::REQ_DATA_W-1:0] req_tdata,  // midi_byte, sample_offset, output_room
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [smx_pkg::RSP_DATA_W-1:0] rsp_tdata,  // msg_byte, msg_length, msg_offset
   output logic                           rsp_tlast   // last_byte
);
   import smx_pkg::*;

   smx_launch_type    launch;
   logic              emit_idle;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;

   smx_collect u_collect (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .emit_idle  (emit_idle),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .launch     (launch)
   );

   smx_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   smx_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .launch     (launch),
      .emit_idle  (emit_idle),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
